[design/tdlm_pkg.sv]
package tdlm_pkg;

  localparam int DEFAULT_MAX_TAPS = 64;

  localparam int KIND_W   = 3;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 24;
  localparam int INDEX_W  = 6;
  localparam int COEF_W   = 24;
  localparam int VALUE_W  = 48;
  localparam int TAPS_W   = 7;
  localparam int PROD_W   = COEF_W + SAMPLE_W;
  localparam int SHIFT    = 15;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_PUSH       = 3'd0;
  localparam kind_t KIND_DOT        = 3'd1;
  localparam kind_t KIND_SCALE_ADD  = 3'd2;
  localparam kind_t KIND_READ_SMP   = 3'd3;
  localparam kind_t KIND_WRITE_COEF = 3'd4;
  localparam kind_t KIND_READ_COEF  = 3'd5;

  // register index, taken from the word address bit of paddr
  localparam logic REG_ACTIVE_TAPS = 1'b0;

  localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd64;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7FFFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 48'sh8000_0000_0000;

endpackage

[design/tdlm_ram.sv]
module tdlm_ram #(
  parameter int WIDTH = tdlm_pkg::SAMPLE_W,
  parameter int DEPTH = tdlm_pkg::DEFAULT_MAX_TAPS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/tap_delay_line_mac_top.sv]
// Throughput: one transaction at a time; dot product and scale-add walk every tap through
//   one shared 24x16 multiplier fed by the two single-port-read memories, one tap per cycle.
// Reset (synchronous, active high): active_taps returns to 64, the oldest pointer to zero,
//   and a clearing pass zeroes both memories before in_ready rises.
module tap_delay_line_mac_top #(
  parameter int MAX_TAPS = tdlm_pkg::DEFAULT_MAX_TAPS
) (
  input  logic                                clk,
  input  logic                                rst,

  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tdlm_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [tdlm_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [tdlm_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,

  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tdlm_pkg::KIND_W-1:0]         kind,
  input  logic signed [tdlm_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [tdlm_pkg::GAIN_W-1:0]  gain,
  input  logic [tdlm_pkg::INDEX_W-1:0]        index,
  input  logic signed [tdlm_pkg::COEF_W-1:0]  coefficient,

  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tdlm_pkg::VALUE_W-1:0] value,
  output logic                                bad_index
);

  localparam int PW    = $clog2(MAX_TAPS);           // slot address width
  localparam int CW    = PW + 1;                     // holds a tap count up to MAX_TAPS
  localparam int KW    = (CW > tdlm_pkg::TAPS_W) ? CW : tdlm_pkg::TAPS_W;
  localparam int SUM_W = tdlm_pkg::PROD_W + PW + 1;
  localparam int ACC_W = (SUM_W > tdlm_pkg::VALUE_W) ? SUM_W : tdlm_pkg::VALUE_W;
  localparam int SH_W  = tdlm_pkg::PROD_W - tdlm_pkg::SHIFT;
  localparam int CS_W  = SH_W + 1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_RUN    = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [tdlm_pkg::TAPS_W-1:0] active_taps;
  logic                        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == tdlm_pkg::REG_ACTIVE_TAPS);

  always_comb begin
    unique case (paddr[2])
      tdlm_pkg::REG_ACTIVE_TAPS: prdata = tdlm_pkg::APB_DATA_W'(active_taps);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_taps <= tdlm_pkg::TAPS_RESET;
    end else if (cfg_we) begin
      active_taps <= pwdata[tdlm_pkg::TAPS_W-1:0];
    end
  end

  // Clamp the register to 1..MAX_TAPS: zero acts as one tap.
  logic [KW-1:0] at_ext;
  logic [CW-1:0] taps;
  logic [PW-1:0] last_j;
  logic [CW-1:0] taps_m1;

  always_comb begin
    at_ext = KW'(active_taps);
    if (at_ext == '0) begin
      taps = CW'(1);
    end else if (at_ext > KW'(MAX_TAPS)) begin
      taps = CW'(MAX_TAPS);
    end else begin
      taps = CW'(at_ext);
    end
    taps_m1 = taps - CW'(1);
    last_j  = taps_m1[PW-1:0];
  end

  // ---------------------------------------------------------------------------
  // Control and latched transaction
  // ---------------------------------------------------------------------------
  logic [2:0]                          state;
  logic [PW-1:0]                       clr_cnt;
  logic [PW-1:0]                       ptr;
  logic [PW-1:0]                       j;
  logic                                v1;
  logic                                v2;
  logic [PW-1:0]                       addr_d1;
  logic [PW-1:0]                       addr_d2;

  tdlm_pkg::kind_t                     kind_q;
  logic signed [tdlm_pkg::SAMPLE_W-1:0] sample_q;
  logic signed [tdlm_pkg::GAIN_W-1:0]  gain_q;
  logic [tdlm_pkg::INDEX_W-1:0]        idx_q;
  logic signed [tdlm_pkg::COEF_W-1:0]  coef_q;

  logic signed [tdlm_pkg::VALUE_W-1:0] res_value;
  logic                                res_bad;

  logic in_fire;
  logic idx_bad;
  logic issue;
  logic out_load;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign idx_bad  = KW'(idx_q) >= KW'(taps);
  assign issue    = (state == S_RUN);
  assign out_load = (state == S_RESULT) && (!out_valid || out_ready);

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic                                 dl_we;
  logic [PW-1:0]                        dl_waddr;
  logic [tdlm_pkg::SAMPLE_W-1:0]        dl_wdata;
  logic [PW-1:0]                        dl_raddr;
  logic [tdlm_pkg::SAMPLE_W-1:0]        dl_rdata;

  logic                                 cf_we;
  logic [PW-1:0]                        cf_waddr;
  logic [tdlm_pkg::COEF_W-1:0]          cf_wdata;
  logic [PW-1:0]                        cf_raddr;
  logic [tdlm_pkg::COEF_W-1:0]          cf_rdata;

  tdlm_ram #(
    .WIDTH(tdlm_pkg::SAMPLE_W),
    .DEPTH(MAX_TAPS)
  ) u_delay_ram (
    .clk  (clk),
    .we   (dl_we),
    .waddr(dl_waddr),
    .wdata(dl_wdata),
    .raddr(dl_raddr),
    .rdata(dl_rdata)
  );

  tdlm_ram #(
    .WIDTH(tdlm_pkg::COEF_W),
    .DEPTH(MAX_TAPS)
  ) u_coef_ram (
    .clk  (clk),
    .we   (cf_we),
    .waddr(cf_waddr),
    .wdata(cf_wdata),
    .raddr(cf_raddr),
    .rdata(cf_rdata)
  );

  // Position from the oldest entry to a physical slot; pointer and position
  // are both below taps, so one conditional subtract wraps.
  logic [PW-1:0] pos_sel;
  logic [CW-1:0] pos_sum;
  logic [CW-1:0] pos_wrap;

  always_comb begin
    pos_sel  = (state == S_EXEC) ? PW'(idx_q) : j;
    pos_sum  = {1'b0, ptr} + {1'b0, pos_sel};
    pos_wrap = (pos_sum >= taps) ? (pos_sum - taps) : pos_sum;
    dl_raddr = pos_wrap[PW-1:0];
    cf_raddr = pos_sel;
  end

  // ---------------------------------------------------------------------------
  // Multiply-accumulate pipeline
  //   issue : read coefficient j and sample at position j
  //   v1    : memory data out, one shared multiply, register the product
  //   v2    : accumulate (dot) or saturate and write back coefficient (scale-add)
  // ---------------------------------------------------------------------------
  logic signed [tdlm_pkg::COEF_W-1:0]   mul_a;
  logic signed [tdlm_pkg::SAMPLE_W-1:0] mul_b;
  logic signed [tdlm_pkg::PROD_W-1:0]   prod;
  logic signed [tdlm_pkg::COEF_W-1:0]   coef_d2;
  logic signed [ACC_W-1:0]              acc;
  logic signed [SH_W-1:0]               prod_sh;
  logic signed [CS_W-1:0]               coef_sum;
  logic signed [tdlm_pkg::COEF_W-1:0]   coef_sat;
  logic [CS_W-tdlm_pkg::COEF_W:0]       cs_top;
  logic [ACC_W-tdlm_pkg::VALUE_W:0]     acc_top;
  logic signed [tdlm_pkg::VALUE_W-1:0]  acc_sat;
  logic                                 op_dot;

  assign op_dot = (kind_q == tdlm_pkg::KIND_DOT);
  assign mul_a  = op_dot ? $signed(cf_rdata) : gain_q;
  assign mul_b  = $signed(dl_rdata);

  always_comb begin
    // floor shift right: arithmetic shift drops the low bits toward minus infinity
    prod_sh  = prod[tdlm_pkg::PROD_W-1:tdlm_pkg::SHIFT];
    coef_sum = CS_W'(coef_d2) + CS_W'(prod_sh);
    cs_top   = coef_sum[CS_W-1:tdlm_pkg::COEF_W-1];
    if ((&cs_top) || !(|cs_top)) begin
      coef_sat = coef_sum[tdlm_pkg::COEF_W-1:0];
    end else if (coef_sum[CS_W-1]) begin
      coef_sat = tdlm_pkg::COEF_MIN;
    end else begin
      coef_sat = tdlm_pkg::COEF_MAX;
    end

    acc_top = acc[ACC_W-1:tdlm_pkg::VALUE_W-1];
    if ((&acc_top) || !(|acc_top)) begin
      acc_sat = acc[tdlm_pkg::VALUE_W-1:0];
    end else if (acc[ACC_W-1]) begin
      acc_sat = tdlm_pkg::VALUE_MIN;
    end else begin
      acc_sat = tdlm_pkg::VALUE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    prod    <= mul_a * mul_b;
    coef_d2 <= $signed(cf_rdata);
    addr_d1 <= j;
    addr_d2 <= addr_d1;
  end

  // Write port selection: clearing pass, single writes, then scale-add write-back.
  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = ptr;
    dl_wdata = sample_q;
    cf_we    = 1'b0;
    cf_waddr = addr_d2;
    cf_wdata = coef_sat;
    if (state == S_CLEAR) begin
      dl_we    = 1'b1;
      dl_waddr = clr_cnt;
      dl_wdata = '0;
      cf_we    = 1'b1;
      cf_waddr = clr_cnt;
      cf_wdata = '0;
    end else if (state == S_EXEC) begin
      dl_we    = (kind_q == tdlm_pkg::KIND_PUSH);
      cf_we    = (kind_q == tdlm_pkg::KIND_WRITE_COEF) && !idx_bad;
      cf_waddr = PW'(idx_q);
      cf_wdata = coef_q;
    end else if (v2 && (kind_q == tdlm_pkg::KIND_SCALE_ADD)) begin
      cf_we    = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [CW-1:0] ptr_inc;

  assign ptr_inc = {1'b0, ptr} + CW'(1);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q   <= kind;
      sample_q <= sample;
      gain_q   <= gain;
      idx_q    <= index;
      coef_q   <= coefficient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      ptr     <= '0;
      j       <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + PW'(1);
          if (clr_cnt == PW'(MAX_TAPS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_value <= '0;
          j         <= '0;
          acc       <= '0;
          case (kind_q) inside
            tdlm_pkg::KIND_PUSH: begin
              ptr     <= (ptr_inc >= taps) ? '0 : ptr_inc[PW-1:0];
              res_bad <= 1'b0;
              state   <= S_RESULT;
            end
            tdlm_pkg::KIND_DOT, tdlm_pkg::KIND_SCALE_ADD: begin
              res_bad <= 1'b0;
              state   <= S_RUN;
            end
            tdlm_pkg::KIND_READ_SMP, tdlm_pkg::KIND_READ_COEF: begin
              res_bad <= idx_bad;
              state   <= idx_bad ? S_RESULT : S_READ;
            end
            tdlm_pkg::KIND_WRITE_COEF: begin
              res_bad <= idx_bad;
              state   <= S_RESULT;
            end
            default: begin
              res_bad <= 1'b0;
              state   <= S_RESULT;
            end
          endcase
        end
        S_READ: begin
          if (kind_q == tdlm_pkg::KIND_READ_SMP) begin
            res_value <= tdlm_pkg::VALUE_W'($signed(dl_rdata));
          end else begin
            res_value <= tdlm_pkg::VALUE_W'($signed(cf_rdata));
          end
          state <= S_RESULT;
        end
        S_RUN: begin
          j <= j + PW'(1);
          if (j == last_j) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            res_value <= op_dot ? acc_sat : '0;
            state     <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (v2 && op_dot) begin
        acc <= acc + ACC_W'(prod);
      end
      // a new tap count restarts the ring at slot zero
      if (cfg_we) begin
        ptr <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the transaction until the consumer takes it
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value     <= res_value;
      bad_index <= res_bad;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The oldest pointer always names a slot in use.
  a_ptr_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, ptr} < taps)
    else $error("oldest pointer outside active taps");

  // The tap counter never runs past the last tap in use.
  a_j_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> ({1'b0, j} < taps))
    else $error("tap counter beyond active taps");

  // Scale-add write-back never hits the coefficient being read in the same cycle.
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (rst)
    (issue && v2 && (kind_q == tdlm_pkg::KIND_SCALE_ADD)) |-> (addr_d2 != j))
    else $error("coefficient read and write-back collide");

  // A finished result reaches the output register once the slot frees.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && (state == S_IDLE)))
    else $error("result not presented after load");

  // The pipeline is empty whenever a new transaction can be taken.
  a_pipe_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!v1 && !v2))
    else $error("accepting while multiply pipeline busy");

endmodule

[test/tdlm_checker.sv]
`timescale 1ns / 100ps

module tdlm_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic                                 pready,
  input  logic [tdlm_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [tdlm_pkg::APB_DATA_W-1:0]      pwdata,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic [tdlm_pkg::KIND_W-1:0]          kind,
  input  logic signed [tdlm_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [tdlm_pkg::GAIN_W-1:0]   gain,
  input  logic [tdlm_pkg::INDEX_W-1:0]         index,
  input  logic signed [tdlm_pkg::COEF_W-1:0]   coefficient,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [tdlm_pkg::VALUE_W-1:0]  value,
  input  logic                                 bad_index,
  output int                                   mismatches,
  output int                                   outstanding
);

  localparam int NTAPS = tdlm_pkg::DEFAULT_MAX_TAPS;

  typedef struct {
    tdlm_pkg::kind_t                     op;
    logic signed [tdlm_pkg::VALUE_W-1:0] value;
    logic                                bad;
  } tap_result_t;

  logic signed [tdlm_pkg::SAMPLE_W-1:0] delay_line [NTAPS];
  logic signed [tdlm_pkg::COEF_W-1:0]   coef_bank  [NTAPS];
  logic [tdlm_pkg::INDEX_W-1:0]         oldest;
  logic [tdlm_pkg::TAPS_W-1:0]          taps_reg;
  tap_result_t                          awaited_results [$];

  // register values outside 1..NTAPS clamp to the nearest legal count
  function automatic int unsigned live_taps();
    if (taps_reg == '0) return 1;
    if (taps_reg > NTAPS) return NTAPS;
    return 32'(taps_reg);
  endfunction

  function automatic int unsigned line_slot(int unsigned pos, int unsigned n);
    int unsigned p;
    p = oldest + pos;
    if (p >= n) p -= n;
    return (p < NTAPS) ? p : 0;
  endfunction

  function automatic tap_result_t tap_line_result(
      tdlm_pkg::kind_t op,
      logic signed [tdlm_pkg::SAMPLE_W-1:0] smp,
      logic signed [tdlm_pkg::GAIN_W-1:0] g,
      logic [tdlm_pkg::INDEX_W-1:0] idx,
      logic signed [tdlm_pkg::COEF_W-1:0] c);
    tap_result_t r;
    int unsigned n;
    int unsigned p;
    int unsigned j;
    longint      acc;
    longint      upd;
    n       = live_taps();
    r.op    = op;
    r.value = '0;
    r.bad   = (idx >= n);
    case (op)
      tdlm_pkg::KIND_PUSH: begin
        delay_line[oldest] = smp;
        p      = oldest + 1;
        oldest = (p >= n) ? '0 : p[tdlm_pkg::INDEX_W-1:0];
        r.bad  = 1'b0;
      end
      tdlm_pkg::KIND_DOT: begin
        acc = 0;
        for (j = 0; j < n; j++)
          acc += longint'(coef_bank[j]) * longint'(delay_line[line_slot(j, n)]);
        if (acc > longint'(tdlm_pkg::VALUE_MAX)) acc = longint'(tdlm_pkg::VALUE_MAX);
        if (acc < longint'(tdlm_pkg::VALUE_MIN)) acc = longint'(tdlm_pkg::VALUE_MIN);
        r.value = acc[tdlm_pkg::VALUE_W-1:0];
        r.bad   = 1'b0;
      end
      tdlm_pkg::KIND_SCALE_ADD: begin
        for (j = 0; j < n; j++) begin
          upd = longint'(coef_bank[j]) +
                ((longint'(g) * longint'(delay_line[line_slot(j, n)])) >>> tdlm_pkg::SHIFT);
          if (upd > longint'(tdlm_pkg::COEF_MAX)) upd = longint'(tdlm_pkg::COEF_MAX);
          if (upd < longint'(tdlm_pkg::COEF_MIN)) upd = longint'(tdlm_pkg::COEF_MIN);
          coef_bank[j] = upd[tdlm_pkg::COEF_W-1:0];
        end
        r.bad = 1'b0;
      end
      tdlm_pkg::KIND_READ_SMP: begin
        if (!r.bad) r.value = tdlm_pkg::VALUE_W'(delay_line[line_slot(32'(idx), n)]);
      end
      tdlm_pkg::KIND_WRITE_COEF: begin
        if (!r.bad) coef_bank[idx] = c;
      end
      tdlm_pkg::KIND_READ_COEF: begin
        if (!r.bad) r.value = tdlm_pkg::VALUE_W'(coef_bank[idx]);
      end
      default: begin
        r.bad = 1'b0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    tap_result_t exp_r;
    if (rst) begin
      for (int i = 0; i < NTAPS; i++) begin
        delay_line[i] = '0;
        coef_bank[i]  = '0;
      end
      oldest   = '0;
      taps_reg = tdlm_pkg::TAPS_RESET;
      awaited_results.delete();
      mismatches = 0;
    end else begin
      // check the result first so a same-edge input cannot mask a stray output
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, got value %0d bad_index %0b",
                   $time, value, bad_index);
        end else begin
          exp_r = awaited_results.pop_front();
          if (value !== exp_r.value || bad_index !== exp_r.bad) begin
            mismatches++;
            $display({"%0t: kind %0d: expected value %0d bad_index %0b, ",
                      "got value %0d bad_index %0b"},
                     $time, exp_r.op, exp_r.value, exp_r.bad, value, bad_index);
          end
        end
      end
      if (psel && penable && pwrite && pready &&
          paddr[tdlm_pkg::APB_ADDR_W-1] == tdlm_pkg::REG_ACTIVE_TAPS) begin
        taps_reg = pwdata[tdlm_pkg::TAPS_W-1:0];
        oldest   = '0;
      end
      if (in_valid && in_ready)
        awaited_results.push_back(tap_line_result(kind, sample, gain, index, coefficient));
    end
    outstanding = awaited_results.size();
  end

endmodule

[test/tap_delay_line_mac_top_tb.sv]
`timescale 1ns / 100ps

module tap_delay_line_mac_top_tb;

  localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
  localparam int QUIET_LIMIT     = 5000;  // cycles without any transaction
  localparam int TAIL_CYCLES     = 80;    // longer than a 64-tap dot product
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int PAUSE_AT        = 110;
  localparam int HOLD_AT         = 50;

  // kinds the block treats as no-ops
  localparam tdlm_pkg::kind_t KIND_SPARE_A = 3'd6;
  localparam tdlm_pkg::kind_t KIND_SPARE_B = 3'd7;

  localparam logic [tdlm_pkg::APB_ADDR_W-1:0] TAPS_ADDR = {tdlm_pkg::REG_ACTIVE_TAPS, 2'b00};

  logic                                 clk         = 1'b0;
  logic                                 rst         = 1'b1;
  logic                                 psel        = 1'b0;
  logic                                 penable     = 1'b0;
  logic                                 pwrite      = 1'b0;
  logic [tdlm_pkg::APB_ADDR_W-1:0]      paddr       = '0;
  logic [tdlm_pkg::APB_DATA_W-1:0]      pwdata      = '0;
  logic [tdlm_pkg::APB_DATA_W-1:0]      prdata;
  logic                                 pready;
  logic                                 in_valid    = 1'b0;
  logic                                 in_ready;
  logic [tdlm_pkg::KIND_W-1:0]          kind        = '0;
  logic signed [tdlm_pkg::SAMPLE_W-1:0] sample      = '0;
  logic signed [tdlm_pkg::GAIN_W-1:0]   gain        = '0;
  logic [tdlm_pkg::INDEX_W-1:0]         index       = '0;
  logic signed [tdlm_pkg::COEF_W-1:0]   coefficient = '0;
  logic                                 out_valid;
  logic                                 out_ready   = 1'b0;
  logic signed [tdlm_pkg::VALUE_W-1:0]  value;
  logic                                 bad_index;

  int mismatches;
  int pending;

  // idle and stall rates in percent; the receiver process reads its own
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int taps_eff      = 64;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tap_delay_line_mac_top #(
    .MAX_TAPS(tdlm_pkg::DEFAULT_MAX_TAPS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .sample     (sample),
    .gain       (gain),
    .index      (index),
    .coefficient(coefficient),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .bad_index  (bad_index)
  );

  tdlm_checker chk (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .sample     (sample),
    .gain       (gain),
    .index      (index),
    .coefficient(coefficient),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .bad_index  (bad_index),
    .mismatches (mismatches),
    .outstanding(pending)
  );

  // Receiver: stall at random at the current rate; on a hold request, drop
  // out_ready for a long stretch so the block backs up into the sender.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_left   = HOLD_CYCLES;
      hold_served = hold_requests;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one transaction, with an optional idle gap first. Called and
  // returns at a falling edge; valid stays high for back-to-back items.
  task automatic send_item(input tdlm_pkg::kind_t k,
                           input logic signed [tdlm_pkg::SAMPLE_W-1:0] s,
                           input logic signed [tdlm_pkg::GAIN_W-1:0] g,
                           input logic [tdlm_pkg::INDEX_W-1:0] ix,
                           input logic signed [tdlm_pkg::COEF_W-1:0] c);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    kind        <= k;
    sample      <= s;
    gain        <= g;
    index       <= ix;
    coefficient <= c;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Write active_taps through the APB port: setup cycle, then access cycle.
  task automatic write_taps(input logic [tdlm_pkg::TAPS_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TAPS_ADDR;
    pwdata  <= {{(tdlm_pkg::APB_DATA_W-tdlm_pkg::TAPS_W){1'b0}}, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    taps_eff = (v == '0) ? 1 :
               (v > tdlm_pkg::DEFAULT_MAX_TAPS) ? tdlm_pkg::DEFAULT_MAX_TAPS : int'(v);
  endtask

  function automatic logic signed [tdlm_pkg::SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(0, 9) != 0) return tdlm_pkg::SAMPLE_W'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return -16'sd1;
    endcase
  endfunction

  // Adaptive steps are usually small; mix those with full-range and extreme values.
  function automatic logic signed [tdlm_pkg::GAIN_W-1:0] pick_q420();
    case ($urandom_range(0, 3))
      0:       return tdlm_pkg::GAIN_W'($urandom);
      1:       return tdlm_pkg::GAIN_W'($urandom_range(0, 8191) - 4096);
      2:       return tdlm_pkg::GAIN_W'($urandom_range(0, 262143) - 131072);
      default: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    endcase
  endfunction

  task automatic send_random();
    int                           roll;
    tdlm_pkg::kind_t              k;
    logic [tdlm_pkg::INDEX_W-1:0] ix;
    roll = $urandom_range(0, 99);
    if (roll < 30)      k = tdlm_pkg::KIND_PUSH;
    else if (roll < 44) k = tdlm_pkg::KIND_DOT;
    else if (roll < 58) k = tdlm_pkg::KIND_SCALE_ADD;
    else if (roll < 70) k = tdlm_pkg::KIND_READ_SMP;
    else if (roll < 82) k = tdlm_pkg::KIND_WRITE_COEF;
    else if (roll < 96) k = tdlm_pkg::KIND_READ_COEF;
    else if (roll < 98) k = KIND_SPARE_A;
    else                k = KIND_SPARE_B;
    // mostly legal indexes, with a share across the full field to hit the bad-index path
    if ($urandom_range(0, 9) < 7) ix = tdlm_pkg::INDEX_W'($urandom_range(0, taps_eff - 1));
    else                          ix = tdlm_pkg::INDEX_W'($urandom_range(0, 63));
    send_item(k, pick_sample(), pick_q420(), ix, pick_q420());
  endtask

  initial begin
    logic [tdlm_pkg::TAPS_W-1:0] phase_taps;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset taps count of 64; extremes of samples and coefficients,
    // saturation of scale-add both ways, and the unused kinds.
    send_item(tdlm_pkg::KIND_READ_COEF,  16'sh0000, 24'sh000000, 6'd0,  24'sh000000);
    send_item(tdlm_pkg::KIND_PUSH,       16'sh7FFF, 24'sh7FFFFF, 6'd63, 24'sh7FFFFF);
    send_item(tdlm_pkg::KIND_PUSH,       16'sh8000, 24'sh800000, 6'd63, 24'sh800000);
    send_item(tdlm_pkg::KIND_WRITE_COEF, 16'sh0000, 24'sh000000, 6'd62, 24'sh7FFFFF);
    send_item(tdlm_pkg::KIND_WRITE_COEF, 16'sh0000, 24'sh000000, 6'd63, 24'sh800000);
    send_item(tdlm_pkg::KIND_READ_SMP,   16'sh0000, 24'sh000000, 6'd63, 24'sh000000);
    send_item(tdlm_pkg::KIND_DOT,        16'sh7FFF, 24'sh7FFFFF, 6'd63, 24'sh7FFFFF);
    send_item(tdlm_pkg::KIND_SCALE_ADD,  16'sh0000, 24'sh7FFFFF, 6'd63, 24'sh000000);
    send_item(tdlm_pkg::KIND_READ_COEF,  16'sh0000, 24'sh000000, 6'd62, 24'sh000000);
    send_item(tdlm_pkg::KIND_READ_COEF,  16'sh0000, 24'sh000000, 6'd63, 24'sh000000);
    send_item(KIND_SPARE_A,              16'sh7FFF, 24'sh7FFFFF, 6'd63, 24'sh7FFFFF);
    send_item(KIND_SPARE_B,              -16'sd1,   -24'sd1,     6'd63, -24'sd1);

    // Three taps: out-of-range indexes, wrap of the oldest pointer.
    drain_results();
    write_taps(7'd3);
    send_item(tdlm_pkg::KIND_READ_SMP,   16'sh0000,   24'sh000000, 6'd3,  24'sh000000);
    send_item(tdlm_pkg::KIND_WRITE_COEF, 16'sh0000,   24'sh000000, 6'd63, 24'sh123456);
    send_item(tdlm_pkg::KIND_READ_COEF,  16'sh0000,   24'sh000000, 6'd63, 24'sh000000);
    send_item(tdlm_pkg::KIND_PUSH,       16'sd1,      24'sh000000, 6'd0,  24'sh000000);
    send_item(tdlm_pkg::KIND_PUSH,       -16'sd1,     24'sh000000, 6'd0,  24'sh000000);
    send_item(tdlm_pkg::KIND_PUSH,       16'sd12345,  24'sh000000, 6'd0,  24'sh000000);
    send_item(tdlm_pkg::KIND_PUSH,       -16'sd20000, 24'sh000000, 6'd0,  24'sh000000);
    send_item(tdlm_pkg::KIND_WRITE_COEF, 16'sh0000,   24'sh000000, 6'd0,  24'sh800000);
    send_item(tdlm_pkg::KIND_DOT,        16'sh0000,   24'sh000000, 6'd0,  24'sh000000);
    send_item(tdlm_pkg::KIND_SCALE_ADD,  16'sh0000,   24'sh800000, 6'd0,  24'sh000000);
    send_item(tdlm_pkg::KIND_READ_SMP,   16'sh0000,   24'sh000000, 6'd2,  24'sh000000);

    // Zero in the register acts as a single tap.
    drain_results();
    write_taps(7'd0);
    send_item(tdlm_pkg::KIND_READ_SMP,   16'sh0000, 24'sh000000, 6'd1,  24'sh000000);
    send_item(tdlm_pkg::KIND_READ_SMP,   16'sh0000, 24'sh000000, 6'd0,  24'sh000000);
    send_item(tdlm_pkg::KIND_PUSH,       16'sh4000, 24'sh000000, 6'd0,  24'sh000000);
    send_item(tdlm_pkg::KIND_DOT,        16'sh0000, 24'sh000000, 6'd0,  24'sh000000);

    // Random phases: each sets a taps count and an idle pattern, pauses for
    // a full drain midway, and the no-idle phases also hold the receiver off.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       phase_taps = 7'd64;
        1:       phase_taps = 7'd1;
        2:       phase_taps = 7'd127;
        3:       phase_taps = 7'd0;
        4:       phase_taps = 7'd5;
        5:       phase_taps = 7'd100;
        6:       phase_taps = 7'd2;
        default: phase_taps = 7'd37;
      endcase
      drain_results();
      write_taps(phase_taps);
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 52; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 52; end
        default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == HOLD_AT && tx_idle_pct == 0) hold_requests++;
        if (i == PAUSE_AT) drain_results();
        send_random();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
